FILE: src/xcd_pkg.sv
`timescale 1ns / 1ps

package xcd_pkg;

    localparam int HEADER_BYTES  = 4;
    localparam int TRAILER_BYTES = 2;
    localparam int POS_W         = 17;
    localparam int CFG_IDX_W     = 2;

    localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
    localparam logic [7:0]       SYNC_VALUE = 8'hAA;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_CEILING = 2'd2;

    localparam logic [7:0] END_MARKER_RST   = 8'h55;
    localparam logic [7:0] TYPE_FLOOR_RST   = 8'h00;
    localparam logic [7:0] TYPE_CEILING_RST = 8'hFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_SYNC     = 3'd2;
    localparam logic [2:0] ST_END      = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;
    localparam logic [2:0] ST_CHECKSUM = 3'd5;
    localparam logic [2:0] ST_TYPE     = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  frame_type;
        logic [15:0] data_length;
    } t_out_beat;

    // classified item handed from front to back
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        is_short;
        logic        sync_ok;
        logic        end_ok;
        logic        len_ok;
        logic        csum_ok;
        logic        type_ok;
        logic [7:0]  frame_type;
        logic [15:0] data_length;
    } t_job;

endpackage

FILE: src/xcd_front.sv
`timescale 1ns / 1ps

module xcd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  xcd_pkg::t_in_beat              i_in,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    output logic                           o_push,
    output xcd_pkg::t_job                  o_job,
    input  logic                           i_full
);
    import xcd_pkg::*;

    logic [7:0]       r_end_marker, r_type_floor, r_type_ceiling;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_xor, r_prev, r_type;
    logic [15:0]      r_len;
    logic             r_sync;

    logic [7:0]       n_type;
    logic [15:0]      n_len;
    logic             n_sync;
    logic [POS_W-1:0] count, expect_cnt, payload_end;
    logic             accept, is_payload;

    assign o_in_ready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    // header capture includes the current byte
    always_comb begin
        n_type = r_type;
        n_len  = r_len;
        n_sync = r_sync;
        case (r_pos)
            POS_W'(0): n_sync = (i_in.data_byte == SYNC_VALUE);
            POS_W'(1): n_type = i_in.data_byte;
            POS_W'(2): n_len  = {r_len[15:8], i_in.data_byte};
            POS_W'(3): n_len  = {i_in.data_byte, r_len[7:0]};
            default:   n_type = r_type;
        endcase
    end

    assign count       = (r_pos != POS_MAX) ? r_pos + POS_W'(1) : POS_MAX;
    assign expect_cnt  = POS_W'(HEADER_BYTES + TRAILER_BYTES) + {1'b0, n_len};
    assign payload_end = POS_W'(HEADER_BYTES) + {1'b0, n_len};
    assign is_payload  = (r_pos >= POS_W'(HEADER_BYTES)) && (r_pos < payload_end);

    always_comb begin
        o_job.kind        = i_in.end_of_buffer ? KIND_VERDICT : KIND_PAYLOAD;
        o_job.data_byte   = i_in.data_byte;
        o_job.is_short    = count < POS_W'(HEADER_BYTES + TRAILER_BYTES);
        o_job.sync_ok     = n_sync;
        o_job.end_ok      = (i_in.data_byte == r_end_marker);
        o_job.len_ok      = (count == expect_cnt);
        // checksum covers every byte before the checksum byte itself
        o_job.csum_ok     = ((r_xor ^ r_prev) == r_prev);
        o_job.type_ok     = (n_type > r_type_floor) && (n_type < r_type_ceiling);
        o_job.frame_type  = n_type;
        o_job.data_length = n_len;
    end

    assign o_push = accept && (i_in.end_of_buffer || is_payload);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker   <= END_MARKER_RST;
            r_type_floor   <= TYPE_FLOOR_RST;
            r_type_ceiling <= TYPE_CEILING_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_END_MARKER:   r_end_marker   <= i_cfg_data;
                REG_TYPE_FLOOR:   r_type_floor   <= i_cfg_data;
                REG_TYPE_CEILING: r_type_ceiling <= i_cfg_data;
                default:          r_end_marker   <= r_end_marker;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_xor  <= '0;
            r_prev <= '0;
            r_type <= '0;
            r_len  <= '0;
            r_sync <= 1'b0;
        end else if (accept) begin
            if (i_in.end_of_buffer) begin
                r_pos  <= '0;
                r_xor  <= '0;
                r_prev <= '0;
                r_type <= '0;
                r_len  <= '0;
                r_sync <= 1'b0;
            end else begin
                r_pos  <= count;
                r_xor  <= r_xor ^ i_in.data_byte;
                r_prev <= i_in.data_byte;
                r_type <= n_type;
                r_len  <= n_len;
                r_sync <= n_sync;
            end
        end
    end

endmodule

FILE: src/xcd_queue.sv
`timescale 1ns / 1ps

module xcd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xcd_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output xcd_pkg::t_job o_job
);
    import xcd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/xcd_back.sv
`timescale 1ns / 1ps

module xcd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    input  xcd_pkg::t_job      i_job,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output xcd_pkg::t_out_beat o_out
);
    import xcd_pkg::*;

    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    logic      load;

    assign load      = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_job_pop = load;

    // first failing check wins
    always_comb begin
        n_out.kind         = i_job.kind;
        n_out.frame_type   = i_job.frame_type;
        n_out.data_length  = i_job.data_length;
        n_out.payload_byte = 8'h00;
        n_out.status       = ST_OK;
        if (i_job.kind == KIND_PAYLOAD) begin
            n_out.payload_byte = i_job.data_byte;
        end else if (i_job.is_short) begin
            n_out.status = ST_SHORT;
        end else if (!i_job.sync_ok) begin
            n_out.status = ST_SYNC;
        end else if (!i_job.end_ok) begin
            n_out.status = ST_END;
        end else if (!i_job.len_ok) begin
            n_out.status = ST_LENGTH;
        end else if (!i_job.csum_ok) begin
            n_out.status = ST_CHECKSUM;
        end else if (!i_job.type_ok) begin
            n_out.status = ST_TYPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: src/xor_checksum_deframer.sv
`timescale 1ns / 1ps

// Byte-serial deframer for frames of sync 0xAA, type, 16-bit little-endian
// length, payload, XOR checksum and end marker. One byte beat is taken per
// cycle while the queue has room; payload bytes come out tentatively as they
// pass, and the beat that carries end_of_buffer yields a single verdict beat
// (status, type, length). Header and trailer bytes yield no output beat. A
// result is registered in the queue between parser and formatter, then in the
// output register. The parser keeps taking bytes while results wait, until
// the QUEUE_DEPTH-entry queue fills. The user must write the config registers
// (end marker, type floor, type ceiling) only while idle; nothing enforces it.
module xor_checksum_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  xcd_pkg::t_in_beat              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output xcd_pkg::t_out_beat             o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import xcd_pkg::*;

    logic push, full, q_valid, pop;
    t_job front_job, back_job;

    xcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_job       (front_job),
        .i_full      (full)
    );

    xcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (back_job)
    );

    xcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_pop   (pop),
        .i_job       (back_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

FILE: src/xcd_checker.sv
`timescale 1ns / 1ps

module xcd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  xcd_pkg::t_in_beat              i_in,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  xcd_pkg::t_out_beat             o_out,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [xcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import xcd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat dropped or changed while stalled");

    a_verdict_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_VERDICT |-> o_out.payload_byte == 8'h00)
        else $error("verdict beat carries a payload byte");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_PAYLOAD |-> o_out.status == ST_OK)
        else $error("payload beat carries a nonzero status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status != 3'd7)
        else $error("status code out of range");

endmodule

bind xor_checksum_deframer xcd_checker u_xcd_checker (.*);

FILE: test/tb_xor_checksum_deframer.sv
`timescale 1ns / 1ps

module tb_xor_checksum_deframer;
    import xcd_pkg::*;

    localparam int DIR_ROWS       = 22;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BEATS    = 90;
    localparam int MAX_REPORTS    = 60;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        logic       typed;
        t_out_beat  want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_beat   in_beat;
    logic       out_valid;
    logic       out_ready;
    t_out_beat  out_beat;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    // copy of the frame state and registers
    logic [POS_W-1:0] fr_pos;
    logic [7:0]       fr_xor;
    logic [7:0]       fr_prev;
    logic             fr_sync;
    logic [7:0]       fr_type;
    logic [15:0]      fr_len;
    logic [7:0]       cfg_end;
    logic [7:0]       cfg_floor;
    logic [7:0]       cfg_ceil;

    t_out_beat results_due[$];
    t_dir_row  dir_rows [DIR_ROWS];
    t_out_beat due;
    int        fail_count = 0;
    int        beats_sent = 0;
    logic      hold_req   = 1'b0;
    logic      sink_gaps  = 1'b1;

    always #5 i_clk = ~i_clk;

    xor_checksum_deframer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic t_out_beat mk_out(input logic kind, input logic [7:0] pb,
                                         input logic [2:0] st, input logic [7:0] ty,
                                         input logic [15:0] len);
        t_out_beat r;
        r.kind         = kind;
        r.payload_byte = pb;
        r.status       = st;
        r.frame_type   = ty;
        r.data_length  = len;
        return r;
    endfunction

    task automatic clear_frame_state();
        fr_pos  = '0;
        fr_xor  = 8'h00;
        fr_prev = 8'h00;
        fr_sync = 1'b0;
        fr_type = 8'h00;
        fr_len  = 16'h0000;
    endtask

    // one byte through the parser: header capture, tentative payload, verdict
    task automatic deframe_byte(input logic [7:0] b, input logic eob,
                                output bit got, output t_out_beat r);
        int         p;
        int         cnt;
        int         frame_bytes;
        logic [7:0] calc;
        logic [2:0] st;
        p   = int'(fr_pos);
        got = 1'b0;
        r   = '0;
        if (p == 0)      fr_sync = (b == SYNC_VALUE);
        else if (p == 1) fr_type = b;
        else if (p == 2) fr_len[7:0]  = b;
        else if (p == 3) fr_len[15:8] = b;

        if (eob) begin
            cnt         = (fr_pos < POS_MAX) ? p + 1 : int'(POS_MAX);
            frame_bytes = HEADER_BYTES + int'(fr_len) + TRAILER_BYTES;
            calc        = fr_xor ^ fr_prev;
            if (cnt < HEADER_BYTES + TRAILER_BYTES)             st = ST_SHORT;
            else if (!fr_sync)                                  st = ST_SYNC;
            else if (b != cfg_end)                              st = ST_END;
            else if (cnt != frame_bytes)                        st = ST_LENGTH;
            else if (calc != fr_prev)                           st = ST_CHECKSUM;
            else if (fr_type <= cfg_floor || fr_type >= cfg_ceil) st = ST_TYPE;
            else                                                st = ST_OK;
            r   = mk_out(KIND_VERDICT, 8'h00, st, fr_type, fr_len);
            got = 1'b1;
            clear_frame_state();
        end else begin
            if (p >= HEADER_BYTES && p < HEADER_BYTES + int'(fr_len)) begin
                r   = mk_out(KIND_PAYLOAD, b, ST_OK, fr_type, fr_len);
                got = 1'b1;
            end
            fr_xor  = fr_xor ^ b;
            fr_prev = b;
            if (fr_pos < POS_MAX) fr_pos = fr_pos + POS_W'(1);
        end
    endtask

    // drive one byte beat; valid is left high after acceptance
    task automatic offer_byte(input logic [7:0] b, input logic eob, input bit gaps,
                              input bit typed, input t_out_beat want);
        bit        got;
        t_out_beat r;
        if (gaps && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= {b, eob};
        do @(posedge i_clk); while (!in_ready);
        beats_sent++;
        deframe_byte(b, eob, got, r);
        if (got) results_due.push_back(typed ? want : r);
    endtask

    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_END_MARKER)      cfg_end   = val;
        else if (idx == REG_TYPE_FLOOR) cfg_floor = val;
        else if (idx == REG_TYPE_CEILING) cfg_ceil = val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] e, input logic [7:0] f, input logic [7:0] c);
        write_reg(REG_END_MARKER, e);
        write_reg(REG_TYPE_FLOOR, f);
        write_reg(REG_TYPE_CEILING, c);
    endtask

    // one buffer: mostly well-formed frames, some damaged, short or noise
    task automatic send_frame(input bit gaps, input int force_len);
        logic [7:0]  fb[$];
        logic [7:0]  ty;
        logic [7:0]  csum;
        logic [7:0]  flip;
        logic [15:0] plen;
        int          mode;
        int          n;
        mode = (force_len >= 0) ? 0 : $urandom_range(0, 99);
        flip = 8'($urandom_range(1, 255));
        if (mode < 80) begin
            if (force_len >= 0)                n = force_len;
            else if ($urandom_range(0, 9) != 0) n = $urandom_range(0, 12);
            else                               n = $urandom_range(13, 48);
            plen = 16'(n);
            if (mode >= 65 && mode < 70)
                ty = $urandom_range(0, 1) ? cfg_floor : cfg_ceil;
            else if (int'(cfg_floor) + 1 < int'(cfg_ceil) && $urandom_range(0, 3) != 0)
                ty = 8'($urandom_range(int'(cfg_floor) + 1, int'(cfg_ceil) - 1));
            else
                ty = 8'($urandom_range(0, 255));
            fb.push_back(SYNC_VALUE);
            fb.push_back(ty);
            fb.push_back(plen[7:0]);
            fb.push_back(plen[15:8]);
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
            csum = 8'h00;
            foreach (fb[i]) csum ^= fb[i];
            fb.push_back(csum);
            fb.push_back(cfg_end);
            n = fb.size();
            if (mode >= 70) begin
                case ($urandom_range(0, 3))
                    0: fb[0] ^= flip;
                    1: fb[n-1] ^= flip;
                    2: fb[n-2] ^= flip;
                    default: begin
                        if (plen != 0 && $urandom_range(0, 1)) fb.delete(4);
                        else fb.insert(4, 8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end else if (mode < 90) begin
            n = $urandom_range(1, 5);
            fb.push_back($urandom_range(0, 1) ? SYNC_VALUE : flip);
            repeat (n - 1) fb.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 24);
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) fb[0] = SYNC_VALUE;
        end
        foreach (fb[i]) offer_byte(fb[i], i == fb.size() - 1, gaps, 1'b0, '0);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none, actual %h", $time, out_beat);
            end else begin
                due = results_due.pop_front();
                check_field("kind", 16'(due.kind), 16'(out_beat.kind));
                check_field("payload_byte", 16'(due.payload_byte),
                            16'(out_beat.payload_byte));
                check_field("status", 16'(due.status), 16'(out_beat.status));
                check_field("frame_type", 16'(due.frame_type), 16'(out_beat.frame_type));
                check_field("data_length", due.data_length, out_beat.data_length);
            end
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                out_ready <= 1'b1;
                hold_req  <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int phase_end;
        in_valid  = 1'b0;
        in_beat   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_END_MARKER;
        cfg_data  = 8'h00;
        i_rst_n   = 1'b0;
        cfg_end   = END_MARKER_RST;
        cfg_floor = TYPE_FLOOR_RST;
        cfg_ceil  = TYPE_CEILING_RST;
        clear_frame_state();

        dir_rows = '{
            // clean frame, type 1, two payload bytes at the extremes
            '{8'hAA, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1, mk_out(KIND_PAYLOAD, 8'h00, ST_OK, 8'h01, 16'd2)},
            '{8'hFF, 1'b0, 1'b1, mk_out(KIND_PAYLOAD, 8'hFF, ST_OK, 8'h01, 16'd2)},
            '{8'h56, 1'b0, 1'b0, '0},
            '{8'h55, 1'b1, 1'b1, mk_out(KIND_VERDICT, 8'h00, ST_OK, 8'h01, 16'd2)},
            // short buffer reports the type captured so far
            '{8'hAA, 1'b0, 1'b0, '0},
            '{8'h07, 1'b1, 1'b1, mk_out(KIND_VERDICT, 8'h00, ST_SHORT, 8'h07, 16'd0)},
            // bad sync and bad end marker together: sync wins
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h05, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h05, 1'b0, 1'b0, '0},
            '{8'h13, 1'b1, 1'b1, mk_out(KIND_VERDICT, 8'h00, ST_SYNC, 8'h05, 16'd0)},
            // buffer ends inside the payload: last byte gives only the verdict
            '{8'hAA, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h05, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h33, 1'b0, 1'b0, '0},
            '{8'h55, 1'b1, 1'b1, mk_out(KIND_VERDICT, 8'h00, ST_LENGTH, 8'h01, 16'd5)}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            offer_byte(dir_rows[k].data, dir_rows[k].eob, 1'b1, dir_rows[k].typed,
                       dir_rows[k].want);
        wait_drained(DRAIN_CYCLES);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                1: set_config(8'h00, 8'h00, 8'h01);  // empty type range
                2: set_config(8'hFF, 8'hFE, 8'hFF);  // empty at the top
                3: set_config(8'h3C, 8'h20, 8'h80);
                4: set_config(8'h55, 8'hC8, 8'h64);  // inverted range
                5: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)),
                              8'($urandom_range(128, 255)));
                6: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                7: begin
                    set_config(END_MARKER_RST, TYPE_FLOOR_RST, TYPE_CEILING_RST);
                    sink_gaps <= 1'b0;
                end
                default: ;
            endcase
            if (ph == 3) begin
                // receiver stalls long while frames keep coming
                hold_req <= 1'b1;
                send_frame(1'b0, 40);
                send_frame(1'b0, 20);
            end
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
                send_frame(ph < 7 && $urandom_range(0, 3) != 0, -1);
            wait_drained(DRAIN_CYCLES);
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
src/xcd_pkg.sv
src/xcd_front.sv
src/xcd_queue.sv
src/xcd_back.sv
src/xor_checksum_deframer.sv
src/xcd_checker.sv
test/tb_xor_checksum_deframer.sv
